FILE: rtl/hbd_pkg.sv
// hbd_pkg: shared types, constants and helpers for the half-band IQ decimator
// used by hbd_tap_cell, hbd_branch and halfband_decimator_iq_q15
package hbd_pkg;

  localparam int LineDepth = 15;
  localparam int NumCoefs  = 4;
  localparam int CentreTap = (LineDepth - 1) / 2;

  localparam int ByteW     = 8;
  localparam int SampleW   = 16;
  localparam int CoefW     = 16;
  localparam int PairW     = SampleW + 1;
  localparam int ProdW     = PairW + CoefW;
  localparam int QShift    = 15;
  localparam int CfgIdxW   = 2;

  localparam int ByteOffset = 127;
  localparam int ByteShift  = 6;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;

  typedef struct packed {
    sample_t re;
    sample_t im;
  } iq_t;

  typedef sample_t line_t  [LineDepth];
  typedef coef_t   coefs_t [NumCoefs];

  typedef struct packed {
    logic prod_en;
    logic out_en;
  } flow_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoefOuter  = 2'd0,
    CfgCoefSecond = 2'd1,
    CfgCoefThird  = 2'd2,
    CfgCoefInner  = 2'd3
  } cfg_idx_e;

  localparam coef_t CoefReset [NumCoefs] = '{
    -16'sd134, 16'sd1078, -16'sd4417, 16'sd19864
  };

  function automatic sample_t byte_to_sample(logic [ByteW-1:0] b);
    logic signed [ByteW:0] off;
    off = $signed({1'b0, b}) - (ByteW + 1)'(ByteOffset);
    return sample_t'(off) <<< ByteShift;
  endfunction

endpackage

FILE: rtl/hbd_tap_cell.sv
// hbd_tap_cell: one complex tap of the delay line, loads d_i (its neighbor, or the new sample) on shift
// depends on hbd_pkg
module hbd_tap_cell (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  hbd_pkg::iq_t d_i,
  output hbd_pkg::iq_t q_o
);
  import hbd_pkg::*;

  iq_t tap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (shift_i) begin
      tap_q <= d_i;
    end
  end

  assign q_o = tap_q;

endmodule

FILE: rtl/hbd_branch.sv
// hbd_branch: symmetric pair sums, registered q15 products and wrapping sum for one rail
// depends on hbd_pkg
module hbd_branch (
  input  logic            clk_i,
  input  hbd_pkg::flow_t  flow_i,
  input  hbd_pkg::line_t  line_i,
  input  hbd_pkg::coefs_t coefs_i,
  output hbd_pkg::sample_t sum_o
);
  import hbd_pkg::*;

  sample_t prod_q [NumCoefs];
  sample_t ctr_q;
  sample_t sum_q;
  sample_t sum_d;

  for (genvar k = 0; k < NumCoefs; k++) begin : g_pair
    logic signed [PairW-1:0] pair;
    logic signed [ProdW-1:0] prod;

    assign pair = PairW'(line_i[2*k]) + PairW'(line_i[LineDepth-1-2*k]);
    assign prod = ProdW'(pair) * ProdW'(coefs_i[k]);

    always_ff @(posedge clk_i) begin
      if (flow_i.prod_en) begin
        prod_q[k] <= prod[QShift +: SampleW];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.prod_en) begin
      ctr_q <= line_i[CentreTap];
    end
  end

  always_comb begin
    sum_d = ctr_q;
    for (int k = 0; k < NumCoefs; k++) begin
      sum_d = sum_d + prod_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.out_en) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: rtl/halfband_decimator_iq_q15.sv
// halfband_decimator_iq_q15: 15-tap half-band decimate-by-two filter on 8-bit IQ bytes
// depends on hbd_pkg, hbd_tap_cell, hbd_branch
// results: each accepted even-phase sample yields one result via the product and sum registers
// throughput: one sample per clock while no result stalls, one result per two samples; a row of tap cells
// shifts on each request, then a registered multiply stage and a sum register
// reset clears taps, phase and pipeline valids and reloads the default coefficients
module halfband_decimator_iq_q15 (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [hbd_pkg::ByteW-1:0] in_real_byte_i,
  input  logic [hbd_pkg::ByteW-1:0] in_imag_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output hbd_pkg::sample_t        out_real_o,
  output hbd_pkg::sample_t        out_imag_o,
  input  logic                    cfg_we_i,
  input  logic [hbd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [hbd_pkg::CoefW-1:0] cfg_data_i
);
  import hbd_pkg::*;

  coef_t  coef_q [NumCoefs];
  iq_t    new_tap;
  iq_t    tap [LineDepth];
  line_t  line_re;
  line_t  line_im;
  flow_t  flow;

  logic odd_q, odd_d;
  logic tap_vld_q, tap_vld_d;
  logic prod_vld_q, prod_vld_d;
  logic out_vld_q, out_vld_d;
  logic accept;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCoefs; k++) begin
        coef_q[k] <= CoefReset[k];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgCoefOuter:  coef_q[0] <= coef_t'(cfg_data_i);
        CfgCoefSecond: coef_q[1] <= coef_t'(cfg_data_i);
        CfgCoefThird:  coef_q[2] <= coef_t'(cfg_data_i);
        CfgCoefInner:  coef_q[3] <= coef_t'(cfg_data_i);
      endcase
    end
  end

  // pipeline flow
  assign flow.out_en  = !out_vld_q || out_ready_i;
  assign flow.prod_en = !prod_vld_q || flow.out_en;
  assign in_ready_o   = !tap_vld_q || flow.prod_en;
  assign accept       = in_valid_i && in_ready_o;

  always_comb begin
    odd_d      = accept ? !odd_q : odd_q;
    tap_vld_d  = accept ? !odd_q : (tap_vld_q && !flow.prod_en);
    prod_vld_d = flow.prod_en ? tap_vld_q : prod_vld_q;
    out_vld_d  = flow.out_en ? prod_vld_q : out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q      <= 1'b0;
      tap_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      odd_q      <= odd_d;
      tap_vld_q  <= tap_vld_d;
      prod_vld_q <= prod_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // delay line, newest sample enters the top cell
  assign new_tap.re = byte_to_sample(in_real_byte_i);
  assign new_tap.im = byte_to_sample(in_imag_byte_i);

  for (genvar i = 0; i < LineDepth; i++) begin : g_cell
    iq_t cell_d;
    if (i == LineDepth - 1) begin : g_top
      assign cell_d = new_tap;
    end else begin : g_mid
      assign cell_d = tap[i+1];
    end

    hbd_tap_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .d_i     (cell_d),
      .q_o     (tap[i])
    );

    assign line_re[i] = tap[i].re;
    assign line_im[i] = tap[i].im;
  end

  hbd_branch u_branch_re (
    .clk_i   (clk_i),
    .flow_i  (flow),
    .line_i  (line_re),
    .coefs_i (coef_q),
    .sum_o   (out_real_o)
  );

  hbd_branch u_branch_im (
    .clk_i   (clk_i),
    .flow_i  (flow),
    .line_i  (line_im),
    .coefs_i (coef_q),
    .sum_o   (out_imag_o)
  );

  assign out_valid_o = out_vld_q;

endmodule

FILE: rtl/hbd_checker.sv
// hbd_checker: port-level assertions for halfband_decimator_iq_q15, bound to the top level
// depends on hbd_pkg
module hbd_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input hbd_pkg::sample_t        out_real_o,
  input hbd_pkg::sample_t        out_imag_o
);
  import hbd_pkg::*;

  // stalled result keeps valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_real_o) && $stable(out_imag_o))
    else $error("result payload changed while stalled");

  // input backpressure only with a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output stall");

  // with no input and the output ready, the pipeline drains and result valid drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_valid_i && out_ready_i) ##1 (!in_valid_i && out_ready_i)
      ##1 (!in_valid_i && out_ready_i) |=> !out_valid_o)
    else $error("result appeared without a request");

endmodule

bind halfband_decimator_iq_q15 hbd_checker u_hbd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_real_o  (out_real_o),
  .out_imag_o  (out_imag_o)
);

FILE: bench/hbd_decim_checker.sv
`timescale 1ns / 1ps
// hbd_decim_checker: watches the sample, result and coefficient ports of the
// half-band IQ decimator, predicts every result and compares it field by field
// depends on hbd_pkg for widths, types and the reset coefficients
module hbd_decim_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [hbd_pkg::ByteW-1:0]         in_real_byte_i,
  input  logic [hbd_pkg::ByteW-1:0]         in_imag_byte_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  hbd_pkg::sample_t                  out_real_i,
  input  hbd_pkg::sample_t                  out_imag_i,
  input  logic                              cfg_we_i,
  input  logic [hbd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [hbd_pkg::CoefW-1:0]         cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import hbd_pkg::*;

  line_t  taps_re;
  line_t  taps_im;
  coefs_t coef_set;
  logic   even_phase;
  iq_t    expected_q [$];
  int     reported;

  function automatic sample_t byte_sample(logic [ByteW-1:0] b);
    return sample_t'((int'(b) - ByteOffset) * (1 << ByteShift));
  endfunction

  function automatic sample_t halfband_sum(line_t taps, coefs_t c);
    sample_t acc;
    int      pair;
    int      prod;
    acc = '0;
    for (int k = 0; k < NumCoefs; k++) begin
      pair = int'(taps[2*k]) + int'(taps[LineDepth-1-2*k]);
      prod = pair * int'(c[k]);
      acc  = acc + sample_t'(prod >>> QShift);
    end
    acc = acc + taps[CentreTap];
    return acc;
  endfunction

  task automatic note_field(input string field, input sample_t want, input sample_t got);
    if (want !== got) begin
      fail_count_o++;
      if (reported < 10) begin
        reported++;
        $display("mismatch %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    iq_t want;
    if (!rst_ni) begin
      foreach (taps_re[n]) begin
        taps_re[n] = '0;
        taps_im[n] = '0;
      end
      coef_set     = CoefReset;
      even_phase   = 1'b1;
      expected_q.delete();
      fail_count_o = 0;
      reported     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (reported < 10) begin
            reported++;
            $display("result with no request pending: re %0d im %0d at %0t",
                     out_real_i, out_imag_i, $realtime);
          end
        end else begin
          want = expected_q.pop_front();
          note_field("out_real", want.re, out_real_i);
          note_field("out_imag", want.im, out_imag_i);
        end
      end
      if (cfg_we_i) begin
        coef_set[cfg_idx_i] = coef_t'(cfg_data_i);
      end
      if (in_valid_i && in_ready_i) begin
        for (int n = 0; n < LineDepth - 1; n++) begin
          taps_re[n] = taps_re[n+1];
          taps_im[n] = taps_im[n+1];
        end
        taps_re[LineDepth-1] = byte_sample(in_real_byte_i);
        taps_im[LineDepth-1] = byte_sample(in_imag_byte_i);
        if (even_phase) begin
          want.re = halfband_sum(taps_re, coef_set);
          want.im = halfband_sum(taps_im, coef_set);
          expected_q.push_back(want);
        end
        even_phase = !even_phase;
      end
    end
    pending_o = expected_q.size();
  end

endmodule

FILE: bench/halfband_decimator_iq_q15_test.sv
`timescale 1ns / 1ps
// halfband_decimator_iq_q15_test: drives samples, coefficient writes and result
// back-pressure into the half-band decimator; hbd_decim_checker does the checking
// depends on hbd_pkg, halfband_decimator_iq_q15 and hbd_decim_checker
module halfband_decimator_iq_q15_test;
  import hbd_pkg::*;

  localparam coef_t CoefMax = 16'sh7fff;
  localparam coef_t CoefMin = 16'sh8000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ByteW-1:0]    in_real_byte;
  logic [ByteW-1:0]    in_imag_byte;
  logic                out_valid;
  logic                out_ready;
  sample_t             out_real;
  sample_t             out_imag;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CoefW-1:0]    cfg_data;
  int                  fail_count;
  int                  pending;
  int                  send_gap_pct;
  int                  stall_pct;

  halfband_decimator_iq_q15 dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_real_byte_i (in_real_byte),
    .in_imag_byte_i (in_imag_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_real_o     (out_real),
    .out_imag_o     (out_imag),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data)
  );

  hbd_decim_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_real_byte_i (in_real_byte),
    .in_imag_byte_i (in_imag_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_real_i     (out_real),
    .out_imag_i     (out_imag),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[halfband_decimator_iq_q15] ERROR");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return ByteW'(ByteOffset);
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic coef_t pick_coef();
    case ($urandom_range(0, 5))
      0:       return CoefMax;
      1:       return CoefMin;
      default: return coef_t'($urandom);
    endcase
  endfunction

  task automatic push_sample(input logic [ByteW-1:0] re_b, input logic [ByteW-1:0] im_b);
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_real_byte <= re_b;
    in_imag_byte <= im_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // results follow only even samples; wait until none is pending, then idle with input valid low
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input coef_t value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
  endtask

  task automatic write_coefs(input coef_t c_outer, input coef_t c_second,
                             input coef_t c_third, input coef_t c_inner);
    write_reg(CfgCoefOuter, c_outer);
    write_reg(CfgCoefSecond, c_second);
    write_reg(CfgCoefThird, c_third);
    write_reg(CfgCoefInner, c_inner);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ByteW-1:0] corner_re [8];
    logic [ByteW-1:0] corner_im [8];
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_real_byte = '0;
    in_imag_byte = '0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    send_gap_pct = 10;
    stall_pct    = 3;
    corner_re = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254};
    corner_im = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd127, 8'd126, 8'd254, 8'd1};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // byte extremes, then an impulse walked through every tap
    for (int i = 0; i < 8; i++) push_sample(corner_re[i], corner_im[i]);
    push_sample(8'd255, 8'd0);
    repeat (15) push_sample(ByteW'(ByteOffset), ByteW'(ByteOffset));
    drain();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       write_coefs(CoefMax, CoefMax, CoefMax, CoefMax);
        1:       write_coefs(CoefMin, CoefMin, CoefMin, CoefMin);
        2:       write_coefs('0, '0, '0, '0);
        3:       write_coefs(CoefReset[0], CoefReset[1], CoefReset[2], CoefReset[3]);
        4:       write_coefs(CoefMax, CoefMin, CoefMin, CoefMax);
        default: write_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
      endcase
      case (p % 3)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 15;
          stall_pct    = 3;
        end
        default: begin
          send_gap_pct = 40;
          stall_pct    = 10;
        end
      endcase
      repeat (160) push_sample(pick_byte(), pick_byte());
      drain();
    end

    send_gap_pct = 0;
    stall_pct    = 0;
    write_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
    repeat (150) push_sample(pick_byte(), pick_byte());
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (fail_count == 0) begin
      $display("[halfband_decimator_iq_q15] OK");
    end else begin
      $display("[halfband_decimator_iq_q15] ERROR");
    end
    $finish;
  end

endmodule
